FILE: src/page_mapped_ftl_with_compaction_macros.svh
// ---------------------------------------------------------------------------
// FTL assertion macros
// Concurrent assertion helpers, clocked on clk_i and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_MAPPED_FTL_WITH_COMPACTION_MACROS_SVH
`define PAGE_MAPPED_FTL_WITH_COMPACTION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FTL_ASSERT_NOW(label, ante, cons)
`define FTL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/ftl_pkg.sv
// ---------------------------------------------------------------------------
// FTL package
// Shared constants, field widths and codes of the flash translation layer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ftl_pkg;
  localparam int LogicalSectorsDef = 2048;
  localparam int BlockSectorsDef   = 32;

  localparam int AddrW  = 11;
  localparam int ByteW  = 8;
  localparam int StatW  = 2;
  localparam int CountW = 13;
  localparam int EraseW = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [StatW-1:0] ST_ERASED   = 2'd2;
  localparam logic [StatW-1:0] ST_FULL     = 2'd3;
endpackage

FILE: src/ftl_ifs.sv
// ---------------------------------------------------------------------------
// FTL channel interfaces
// Valid/ready channels for operations in and results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ftl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [ftl_pkg::AddrW-1:0] logical_addr;
  logic [ftl_pkg::ByteW-1:0] data_byte;
  modport source (output valid, opcode, logical_addr, data_byte, input ready);
  modport sink   (input valid, opcode, logical_addr, data_byte, output ready);
endinterface

interface ftl_out_if;
  logic                       valid;
  logic                       ready;
  logic [ftl_pkg::StatW-1:0]  status;
  logic [ftl_pkg::AddrW-1:0]  phys_addr;
  logic [ftl_pkg::ByteW-1:0]  read_data;
  logic [ftl_pkg::CountW-1:0] writes_done;
  logic [ftl_pkg::EraseW-1:0] erases_done;
  logic [ftl_pkg::CountW-1:0] reads_done;
  modport source (output valid, status, phys_addr, read_data, writes_done,
                  erases_done, reads_done, input ready);
  modport sink   (input valid, status, phys_addr, read_data, writes_done,
                  erases_done, reads_done, output ready);
endinterface

FILE: src/ftl_ram.sv
// ---------------------------------------------------------------------------
// FTL generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ftl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: src/page_mapped_ftl_with_compaction.sv
// ---------------------------------------------------------------------------
// Page-mapped flash translation layer with compaction
// Map table and sector store in two RAMs; compaction done in place.
// ---------------------------------------------------------------------------
// Channel   Dir  Modport  Carries
// in_i      in   sink     opcode, logical_addr, data_byte
// out_o     out  source   status, phys_addr, read_data, write/erase/read counts
//
// A mapped read or write reaches the output register after map RAM read,
// evaluate, sector RAM access and result load; input reopens only once the
// result is loaded, so the block works on one transaction at a time. Unmapped
// reads and rejected writes skip the sector access.
// A write with the log full first compacts: a pass that reads one sector per
// cycle and moves live ones down to the write pointer, then a sweep that
// clears the tail, with input stalled throughout.
// After reset a clearing pass initialises both RAMs; no transaction is
// accepted meanwhile.
// The result sits in an output register; the next transaction is taken while
// it waits, but a finished one holds until the register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_mapped_ftl_with_compaction_macros.svh"
module page_mapped_ftl_with_compaction #(
  parameter int LOGICAL_SECTORS = ftl_pkg::LogicalSectorsDef,
  parameter int BLOCK_SECTORS   = ftl_pkg::BlockSectorsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ftl_in_if.sink    in_i,
  ftl_out_if.source out_o
);
  localparam int PaW   = $clog2(LOGICAL_SECTORS);
  localparam int WpW   = $clog2(LOGICAL_SECTORS + 1);
  localparam int MapW  = PaW + 1;
  localparam int SecW  = 1 + PaW + ftl_pkg::ByteW;
  localparam int CntW  = $clog2(2 * LOGICAL_SECTORS + 2);
  localparam int ErsW  = $clog2(2 * (LOGICAL_SECTORS / BLOCK_SECTORS) + 1);
  localparam int BlkW  = $clog2(BLOCK_SECTORS);

  localparam logic [WpW-1:0]  WpFull = WpW'(LOGICAL_SECTORS);
  localparam logic [PaW-1:0]  PaLast = PaW'(LOGICAL_SECTORS - 1);
  localparam logic [BlkW-1:0] BlkLast = BlkW'(BLOCK_SECTORS - 1);

  // state codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MAPRD = 4'd2;
  localparam logic [3:0] S_MAP   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  logic                      op_q, op_d;
  logic [PaW-1:0]            addr_q, addr_d;
  logic [ftl_pkg::ByteW-1:0] byte_q, byte_d;
  logic [WpW-1:0]            wp_q, wp_d;
  logic [WpW-1:0]            idx_q, idx_d;      // compaction read / sweep index
  logic                      pend_q, pend_d;    // sector read in flight
  logic [BlkW-1:0]           blk_q, blk_d;      // position within block
  logic                      bflag_q, bflag_d;  // block held a live sector
  logic [PaW-1:0]            clr_q, clr_d;

  logic [ftl_pkg::StatW-1:0] status_q, status_d;
  logic [PaW-1:0]            phys_q, phys_d;
  logic [ftl_pkg::ByteW-1:0] rdata_q, rdata_d;
  logic [CntW-1:0]           w_q, w_d, r_q, r_d;
  logic [ErsW-1:0]           e_q, e_d;

  logic                       ov_q, ov_d;
  logic [ftl_pkg::StatW-1:0]  os_q, os_d;
  logic [ftl_pkg::AddrW-1:0]  op_addr_q, op_addr_d;
  logic [ftl_pkg::ByteW-1:0]  od_q, od_d;
  logic [ftl_pkg::CountW-1:0] ow_q, ow_d, or_q, or_d;
  logic [ftl_pkg::EraseW-1:0] oe_q, oe_d;

  // RAM ports
  logic            map_we, map_re, sec_we, sec_re;
  logic [PaW-1:0]  map_waddr, map_raddr, sec_waddr, sec_raddr;
  logic [MapW-1:0] map_wdata, map_rdata;
  logic [SecW-1:0] sec_wdata, sec_rdata;

  logic            sec_valid;
  logic [PaW-1:0]  sec_owner;
  logic            map_unmapped;
  logic            in_fire;

  assign sec_valid    = sec_rdata[SecW-1];
  assign sec_owner    = sec_rdata[SecW-2:ftl_pkg::ByteW];
  assign map_unmapped = map_rdata[MapW-1];
  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid & in_i.ready;

  ftl_ram #(.Width(MapW), .Depth(LOGICAL_SECTORS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  ftl_ram #(.Width(SecW), .Depth(LOGICAL_SECTORS)) u_sec_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .waddr_i (sec_waddr),
    .wdata_i (sec_wdata),
    .re_i    (sec_re),
    .raddr_i (sec_raddr),
    .rdata_o (sec_rdata)
  );

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    addr_d   = addr_q;
    byte_d   = byte_q;
    wp_d     = wp_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    blk_d    = blk_q;
    bflag_d  = bflag_q;
    clr_d    = clr_q;
    status_d = status_q;
    phys_d   = phys_q;
    rdata_d  = rdata_q;
    w_d      = w_q;
    r_d      = r_q;
    e_d      = e_q;

    ov_d      = ov_q & ~out_o.ready;
    os_d      = os_q;
    op_addr_d = op_addr_q;
    od_d      = od_q;
    ow_d      = ow_q;
    or_d      = or_q;
    oe_d      = oe_q;

    map_we    = 1'b0;
    map_waddr = addr_q;
    map_wdata = {1'b0, wp_q[PaW-1:0]};
    map_re    = 1'b0;
    map_raddr = addr_q;
    sec_we    = 1'b0;
    sec_waddr = wp_q[PaW-1:0];
    sec_wdata = '0;
    sec_re    = 1'b0;
    sec_raddr = idx_q[PaW-1:0];

    case (state_q)
      S_CLR: begin
        // map to all ones (unmapped), sectors to erased
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = '1;
        sec_we    = 1'b1;
        sec_waddr = clr_q;
        sec_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == PaLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d     = in_i.opcode;
          addr_d   = PaW'(in_i.logical_addr);
          byte_d   = in_i.data_byte;
          status_d = ftl_pkg::ST_OK;
          phys_d   = '0;
          rdata_d  = '0;
          w_d      = '0;
          r_d      = '0;
          e_d      = '0;
          if (32'(in_i.logical_addr) >= 32'(LOGICAL_SECTORS)) begin
            status_d = (in_i.opcode == ftl_pkg::OP_READ) ? ftl_pkg::ST_UNMAPPED
                                                         : ftl_pkg::ST_FULL;
            state_d  = S_DONE;
          end else if ((in_i.opcode == ftl_pkg::OP_WRITE) && (wp_q == WpFull)) begin
            wp_d    = '0;
            idx_d   = '0;
            pend_d  = 1'b0;
            blk_d   = '0;
            bflag_d = 1'b0;
            state_d = S_CMP;
          end else begin
            state_d = S_MAPRD;
          end
        end
      end
      S_CMP: begin
        // issue one sector read a cycle
        if (idx_q != WpFull) begin
          sec_re = 1'b1;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        // the sector read last cycle: move live ones down to wp
        if (pend_q) begin
          r_d = r_q + (sec_valid ? CntW'(2) : CntW'(1));
          if (sec_valid) begin
            sec_we    = 1'b1;
            sec_waddr = wp_q[PaW-1:0];
            sec_wdata = sec_rdata;
            map_we    = 1'b1;
            map_waddr = sec_owner;
            map_wdata = {1'b0, wp_q[PaW-1:0]};
            wp_d      = wp_q + 1'b1;
            w_d       = w_q + CntW'(2);
          end
          if (blk_q == BlkLast) begin
            blk_d   = '0;
            bflag_d = 1'b0;
            e_d     = e_q + ((bflag_q | sec_valid) ? ErsW'(2) : ErsW'(1));
          end else begin
            blk_d   = blk_q + 1'b1;
            bflag_d = bflag_q | sec_valid;
          end
        end else if (idx_q == WpFull) begin
          idx_d   = wp_q;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // erase the tail behind the compacted data
        if (idx_q != WpFull) begin
          sec_we    = 1'b1;
          sec_waddr = idx_q[PaW-1:0];
          sec_wdata = '0;
          idx_d     = idx_q + 1'b1;
        end else begin
          state_d = S_MAPRD;
        end
      end
      S_MAPRD: begin
        map_re  = 1'b1;
        state_d = S_MAP;
      end
      S_MAP: begin
        if (op_q == ftl_pkg::OP_WRITE) begin
          if (wp_q == WpFull) begin
            status_d = ftl_pkg::ST_FULL;
            phys_d   = map_unmapped ? '0 : map_rdata[PaW-1:0];
            state_d  = S_DONE;
          end else begin
            if (!map_unmapped) begin
              // drop the old copy
              sec_we    = 1'b1;
              sec_waddr = map_rdata[PaW-1:0];
              sec_wdata = '0;
              r_d       = r_q + 1'b1;
            end
            state_d = S_WR;
          end
        end else begin
          if (map_unmapped) begin
            status_d = ftl_pkg::ST_UNMAPPED;
            state_d  = S_DONE;
          end else begin
            sec_re    = 1'b1;
            sec_raddr = map_rdata[PaW-1:0];
            phys_d    = map_rdata[PaW-1:0];
            state_d   = S_RD;
          end
        end
      end
      S_WR: begin
        sec_we    = 1'b1;
        sec_waddr = wp_q[PaW-1:0];
        sec_wdata = {1'b1, addr_q, byte_q};
        map_we    = 1'b1;
        map_waddr = addr_q;
        map_wdata = {1'b0, wp_q[PaW-1:0]};
        w_d       = w_q + 1'b1;
        phys_d    = wp_q[PaW-1:0];
        wp_d      = wp_q + 1'b1;
        state_d   = S_DONE;
      end
      S_RD: begin
        rdata_d  = sec_rdata[ftl_pkg::ByteW-1:0];
        r_d      = r_q + 1'b1;
        status_d = (sec_rdata[ftl_pkg::ByteW-1:0] == '0) ? ftl_pkg::ST_ERASED
                                                         : ftl_pkg::ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          os_d      = status_q;
          op_addr_d = ftl_pkg::AddrW'(phys_q);
          od_d      = rdata_q;
          ow_d      = ftl_pkg::CountW'(w_q);
          or_d      = ftl_pkg::CountW'(r_q);
          oe_d      = ftl_pkg::EraseW'(e_q);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      wp_q    <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      blk_q   <= '0;
      bflag_q <= 1'b0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      blk_q   <= blk_d;
      bflag_q <= bflag_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    addr_q    <= addr_d;
    byte_q    <= byte_d;
    status_q  <= status_d;
    phys_q    <= phys_d;
    rdata_q   <= rdata_d;
    w_q       <= w_d;
    r_q       <= r_d;
    e_q       <= e_d;
    os_q      <= os_d;
    op_addr_q <= op_addr_d;
    od_q      <= od_d;
    ow_q      <= ow_d;
    or_q      <= or_d;
    oe_q      <= oe_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = os_q;
  assign out_o.phys_addr   = op_addr_q;
  assign out_o.read_data   = od_q;
  assign out_o.writes_done = ow_q;
  assign out_o.erases_done = oe_q;
  assign out_o.reads_done  = or_q;

  `FTL_ASSERT_NOW(a_wp_bound, 1'b1, wp_q <= WpFull)
  `FTL_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_i.ready)
  `FTL_ASSERT_NOW(a_cmp_order, state_q == S_CMP, wp_q <= idx_q)
  `FTL_ASSERT_NEXT(a_result_loaded, (state_q == S_DONE) && !ov_q, ov_q)
endmodule

FILE: dv/tb_page_mapped_ftl_with_compaction.sv
// ---------------------------------------------------------------------------
// FTL testbench
// Self-checking bench for the page-mapped FTL. A scoreboard class keeps its
// own copy of the map and the sector store. It works out the answer to every
// accepted operation and checks each result, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_page_mapped_ftl_with_compaction;
  localparam int NLog      = ftl_pkg::LogicalSectorsDef;
  localparam int NBlk      = ftl_pkg::BlockSectorsDef;
  localparam int NPhys     = NLog + NBlk;
  localparam int SpareBase = NLog;
  localparam int NoMap     = -1;
  localparam int AddrW     = ftl_pkg::AddrW;
  localparam int ByteW     = ftl_pkg::ByteW;
  localparam int StatW     = ftl_pkg::StatW;
  localparam int CountW    = ftl_pkg::CountW;
  localparam int EraseW    = ftl_pkg::EraseW;
  // Cycles without any transaction before the run is abandoned. The worst
  // case is a compaction waiting on a long output hold.
  localparam int StallLimit = 20000;
  localparam int LongHold   = 300;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [AddrW-1:0]  phys_addr;
    logic [ByteW-1:0]  read_data;
    logic [CountW-1:0] writes_done;
    logic [EraseW-1:0] erases_done;
    logic [CountW-1:0] reads_done;
  } ftl_result_t;

  // Shadow of the translation layer, plus the queue of answers still owed.
  class ftl_scoreboard;
    int               map_tbl[NLog];
    logic [ByteW-1:0] sec_data[NPhys];
    int               sec_owner[NPhys];
    bit               sec_valid[NPhys];
    int               wr_ptr;
    ftl_result_t      owed[$];
    int               errors;
    int               n_checked, n_compactions, n_full, n_erased_reads, n_unmapped;

    function new();
      foreach (map_tbl[i]) map_tbl[i] = NoMap;
      foreach (sec_data[i]) begin
        sec_data[i]  = '0;
        sec_owner[i] = 0;
        sec_valid[i] = 1'b0;
      end
      wr_ptr = 0;
    endfunction

    function void wipe_block(int first);
      for (int k = 0; k < NBlk; k++) begin
        sec_data[first+k]  = '0;
        sec_valid[first+k] = 1'b0;
        sec_owner[first+k] = 0;
      end
    endfunction

    // Packs live sectors to the front, one data block at a time via the spare.
    function void compact(inout int w, inout int e, inout int r);
      int dst, live, src;
      dst = 0;
      n_compactions++;
      for (int b = 0; b < NLog / NBlk; b++) begin
        live = 0;
        for (int k = 0; k < NBlk; k++) begin
          src = b * NBlk + k;
          r++;
          if (sec_valid[src]) begin
            sec_data[SpareBase+live]  = sec_data[src];
            sec_owner[SpareBase+live] = sec_owner[src];
            sec_valid[SpareBase+live] = 1'b1;
            live++;
            w++;
          end
        end
        wipe_block(b * NBlk);
        e++;
        if (live != 0) begin
          for (int t = 0; t < live; t++) begin
            map_tbl[sec_owner[SpareBase+t]] = dst;
            sec_data[dst]  = sec_data[SpareBase+t];
            sec_owner[dst] = sec_owner[SpareBase+t];
            sec_valid[dst] = 1'b1;
            dst++;
            r++;
            w++;
          end
          wipe_block(SpareBase);
          e++;
        end
      end
      wr_ptr = dst;
    endfunction

    function void note_op(logic op, logic [AddrW-1:0] addr, logic [ByteW-1:0] dat);
      ftl_result_t res;
      int w, e, r, old, p;
      w = 0; e = 0; r = 0;
      res = '0;
      if (op == ftl_pkg::OP_WRITE) begin
        if (wr_ptr >= NLog) compact(w, e, r);
        old = map_tbl[addr];
        if (wr_ptr >= NLog) begin
          res.status    = ftl_pkg::ST_FULL;
          res.phys_addr = (old == NoMap) ? '0 : old[AddrW-1:0];
          n_full++;
        end else begin
          p = wr_ptr;
          if (old != NoMap) begin
            sec_valid[old] = 1'b0;
            r++;
          end
          wr_ptr++;
          map_tbl[addr] = p;
          sec_data[p]   = dat;
          sec_owner[p]  = addr;
          sec_valid[p]  = 1'b1;
          w++;
          res.status    = ftl_pkg::ST_OK;
          res.phys_addr = p[AddrW-1:0];
        end
      end else begin
        p = map_tbl[addr];
        if (p == NoMap) begin
          res.status = ftl_pkg::ST_UNMAPPED;
          n_unmapped++;
        end else begin
          res.phys_addr = p[AddrW-1:0];
          res.read_data = sec_data[p];
          r = 1;
          res.status = (sec_data[p] == '0) ? ftl_pkg::ST_ERASED : ftl_pkg::ST_OK;
          if (sec_data[p] == '0) n_erased_reads++;
        end
      end
      res.writes_done = w[CountW-1:0];
      res.erases_done = e[EraseW-1:0];
      res.reads_done  = r[CountW-1:0];
      owed.push_back(res);
    endfunction

    function void check_result(ftl_result_t got);
      ftl_result_t exp;
      if (owed.size() == 0) begin
        $error("result with no operation outstanding");
        errors++;
        return;
      end
      exp = owed.pop_front();
      n_checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.phys_addr !== exp.phys_addr) begin
        $error("phys_addr: expected %0d, got %0d", exp.phys_addr, got.phys_addr); errors++;
      end
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %0d, got %0d", exp.read_data, got.read_data); errors++;
      end
      if (got.writes_done !== exp.writes_done) begin
        $error("writes_done: expected %0d, got %0d", exp.writes_done, got.writes_done);
        errors++;
      end
      if (got.erases_done !== exp.erases_done) begin
        $error("erases_done: expected %0d, got %0d", exp.erases_done, got.erases_done);
        errors++;
      end
      if (got.reads_done !== exp.reads_done) begin
        $error("reads_done: expected %0d, got %0d", exp.reads_done, got.reads_done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ftl_in_if  in_ch();
  ftl_out_if out_ch();

  page_mapped_ftl_with_compaction u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  ftl_scoreboard sb;
  bit quiet;      // no idling on either side in the closing stretch
  bit hold_req;   // asks the receiver for one long hold-off
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor: sampled at the edge, before any NBA of this step lands.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.phys_addr, out_ch.read_data,
                       out_ch.writes_done, out_ch.erases_done, out_ch.reads_done});
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one operation and waits for its transaction. A gap, if any, is
  // taken before valid goes up, so valid never drops and rises in one step.
  task automatic send_op(logic op, logic [AddrW-1:0] addr, logic [ByteW-1:0] dat);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.logical_addr <= addr;
    in_ch.data_byte    <= dat;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op, addr, dat);
  endtask

  function automatic logic [ByteW-1:0] rand_byte();
    return ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // Hot set of a few addresses so overwrites and stale copies are common.
  function automatic logic [AddrW-1:0] rand_addr();
    case ($urandom_range(0, 3))
      0:       return 11'($urandom_range(0, NLog - 1));
      1:       return ($urandom_range(0, 1) == 0) ? 11'd0 : 11'(NLog - 1);
      default: return 11'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= ftl_pkg::OP_WRITE;
    in_ch.logical_addr <= '0;
    in_ch.data_byte    <= '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unmapped reads at both ends, extreme bytes, a zero byte,
    // overwrite of a mapped sector, then read-backs.
    send_op(ftl_pkg::OP_READ,  11'd0,        8'd0);
    send_op(ftl_pkg::OP_READ,  11'(NLog-1),  8'hFF);
    send_op(ftl_pkg::OP_WRITE, 11'd0,        8'd1);
    send_op(ftl_pkg::OP_WRITE, 11'(NLog-1),  8'd255);
    send_op(ftl_pkg::OP_WRITE, 11'h555,      8'hAA);
    send_op(ftl_pkg::OP_WRITE, 11'h2AA,      8'h55);
    send_op(ftl_pkg::OP_WRITE, 11'd7,        8'd0);
    send_op(ftl_pkg::OP_READ,  11'd7,        8'd0);
    send_op(ftl_pkg::OP_WRITE, 11'd0,        8'd128);
    send_op(ftl_pkg::OP_WRITE, 11'd0,        8'd127);
    send_op(ftl_pkg::OP_READ,  11'd0,        8'd0);
    send_op(ftl_pkg::OP_READ,  11'(NLog-1),  8'd0);
    send_op(ftl_pkg::OP_READ,  11'h555,      8'd0);
    send_op(ftl_pkg::OP_READ,  11'h2AA,      8'd0);
    send_op(ftl_pkg::OP_WRITE, 11'd7,        8'd9);
    send_op(ftl_pkg::OP_READ,  11'd7,        8'd0);

    // Random mix, write heavy; the long output hold comes part way in.
    for (int i = 0; i < 1000; i++) begin
      if (i == 300) hold_req = 1'b1;
      if ($urandom_range(0, 9) < 7)
        send_op(ftl_pkg::OP_WRITE, rand_addr(), rand_byte());
      else
        send_op(ftl_pkg::OP_READ, rand_addr(), 8'($urandom));
    end

    // Closing stretch without idling, mostly reads.
    quiet = 1'b1;
    for (int i = 0; i < 184; i++)
      send_op(($urandom_range(0, 3) == 0) ? ftl_pkg::OP_WRITE : ftl_pkg::OP_READ,
              rand_addr(), rand_byte());
    in_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d compactions, %0d full rejects,", sb.n_checked,
             sb.n_compactions, sb.n_full);
    $display("%0d unmapped reads, %0d reads of zero-byte sectors", sb.n_unmapped,
             sb.n_erased_reads);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

FILE: page_mapped_ftl_with_compaction.f
+incdir+src
src/ftl_pkg.sv
src/ftl_ifs.sv
src/ftl_ram.sv
src/page_mapped_ftl_with_compaction.sv
dv/tb_page_mapped_ftl_with_compaction.sv
